// ===== rtl/assert_macros.svh =====
// assertion macros shared by the formatter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/dfmt_pkg.sv =====
// types, constants and the decimal weight table of the field formatter
package dfmt_pkg;

  localparam int REM_W = 32;
  localparam int CMP_W = 33;
  localparam int WEIGHT_W = 30;

  localparam logic [3:0] POS_TOP = 4'd9;
  localparam logic [7:0] GLYPH_RESET = 8'd16;
  localparam logic [5:0] CODE_SPACE = 6'd32;
  localparam logic [5:0] CODE_ZERO = 6'd48;
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [7:0] PAGE_STEP = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic             ge;
    logic [REM_W-1:0] diff;
  } csub_res_t;

  function automatic logic [WEIGHT_W-1:0] dec_weight(input logic [3:0] pos);
    logic [WEIGHT_W-1:0] w;
    case (pos)
      4'd0:    w = 30'd1;
      4'd1:    w = 30'd10;
      4'd2:    w = 30'd100;
      4'd3:    w = 30'd1000;
      4'd4:    w = 30'd10000;
      4'd5:    w = 30'd100000;
      4'd6:    w = 30'd1000000;
      4'd7:    w = 30'd10000000;
      4'd8:    w = 30'd100000000;
      4'd9:    w = 30'd1000000000;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dfmt_csub.sv =====
// shared compare and subtract unit for the digit extraction steps
module dfmt_csub (
  input  logic [dfmt_pkg::CMP_W-1:0] a,
  input  logic [dfmt_pkg::CMP_W-1:0] b,
  output dfmt_pkg::csub_res_t        res
);
  import dfmt_pkg::*;

  logic [CMP_W:0] sum;

  // borrow out of a - b means a < b
  assign sum      = {1'b0, a} + {1'b0, ~b} + {{CMP_W{1'b0}}, 1'b1};
  assign res.ge   = sum[CMP_W];
  assign res.diff = sum[REM_W-1:0];

endmodule

// ===== rtl/decimal_field_formatter_unit.sv =====
// decimal field formatter: one request in, one character out per field digit
// each request of nonzero width walks all ten decimal positions with one compare-subtract step per
// weight bit (8, 4, 2, 1 times 10^p), and emits one character after each position inside the field
// a zero-width request is taken but returns no character; a new request is held off (in_stall)
// until the last character of the current one has been issued, and output stalls hold the emit
// rst is synchronous: sequencer idle, output empty, glyph_size back to 16
`include "assert_macros.svh"

module decimal_field_formatter_unit #(
  parameter int MAX_DIGITS   = 10,
  parameter int COLUMN_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] number,
  input  logic [3:0]  digit_count,
  input  logic [7:0]  start_column,
  input  logic [7:0]  start_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  char_code,
  output logic [7:0]  column,
  output logic [7:0]  page,
  output logic        last
);
  import dfmt_pkg::*;

  localparam logic [3:0] MAX_W     = 4'(MAX_DIGITS);
  localparam logic [7:0] COL_LIMIT = 8'(COLUMN_COUNT);

  state_t           state;
  logic [7:0]       glyph_size;
  logic [REM_W-1:0] rem;
  logic [3:0]       width;
  logic [3:0]       pos;
  logic [1:0]       bitk;
  logic [3:0]       digit;
  logic             showing;
  logic [7:0]       col_acc;
  logic [7:0]       page0;
  logic [6:0]       pitch;

  logic             cfg_wr;
  logic [3:0]       w_clamp;
  logic [CMP_W-1:0] cmp_a;
  logic [CMP_W-1:0] cmp_b;
  csub_res_t        sub;
  logic             out_free;
  logic             is_last;
  logic             blank;
  logic             wrap;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, glyph_size};

  assign in_stall = (state != ST_IDLE);
  assign w_clamp  = (digit_count > MAX_W) ? MAX_W : digit_count;

  assign cmp_a = {1'b0, rem};
  assign cmp_b = CMP_W'(dec_weight(pos)) << bitk;

  dfmt_csub u_csub (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (sub)
  );

  assign out_free = !out_valid || !out_stall;
  assign is_last  = (pos == 4'd0);
  assign blank    = !showing && !is_last && (digit == 4'd0);
  assign wrap     = (col_acc >= COL_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      glyph_size <= GLYPH_RESET;
    end else begin
      if (cfg_wr && !paddr[2]) begin
        glyph_size <= pwdata[7:0];
      end
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rem     <= number;
            width   <= w_clamp;
            pos     <= POS_TOP;
            bitk    <= 2'd3;
            digit   <= 4'd0;
            showing <= 1'b0;
            col_acc <= start_column;
            page0   <= start_page;
            pitch   <= glyph_size[7:1];
            if (w_clamp != 4'd0) begin
              state <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (sub.ge) begin
            rem <= sub.diff;
          end
          digit[bitk] <= sub.ge;
          if (bitk == 2'd0) begin
            // positions above the field width are only stripped off
            if (pos < width) begin
              state <= ST_EMIT;
            end else begin
              pos  <= pos - 4'd1;
              bitk <= 2'd3;
            end
          end else begin
            bitk <= bitk - 2'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            char_code <= blank ? CODE_SPACE : (CODE_ZERO + {2'd0, digit});
            column    <= wrap ? 8'd0 : col_acc;
            page      <= wrap ? (page0 + PAGE_STEP) : page0;
            last      <= is_last;
            showing   <= showing || !blank;
            col_acc   <= col_acc + {1'b0, pitch};
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos - 4'd1;
              bitk  <= 2'd3;
              digit <= 4'd0;
              state <= ST_CALC;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_pos_range, clk, rst, (state == ST_CALC) |-> (pos <= POS_TOP))
  `ASSERT_IMPLY(a_digit_range, clk, rst, (state == ST_EMIT) |-> (digit <= DIGIT_MAX))
  `ASSERT_IMPLY(a_last_ends, clk, rst, (state == ST_EMIT && out_free && is_last) |=> (state == ST_IDLE && out_valid && last))
  `ASSERT_IMPLY(a_code_set, clk, rst, out_valid |-> (char_code == CODE_SPACE || (char_code >= CODE_ZERO && char_code <= CODE_ZERO + 6'(DIGIT_MAX))))
  `ASSERT_NEVER(a_last_blank, clk, rst, out_valid && last && char_code == CODE_SPACE)

endmodule

// ===== sim/decimal_field_formatter_unit_tb.sv =====
// testbench of the decimal field formatter: directed and random requests against a predictor
module decimal_field_formatter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfmt_pkg::*;

  localparam int MAX_DIGITS = 10;
  localparam int COLUMN_COUNT = 128;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [2:0] GLYPH_REG_ADDR = 3'd0;
  localparam logic [2:0] UNUSED_REG_ADDR = 3'd4;

  typedef struct packed {
    logic [5:0] code;
    logic [7:0] column;
    logic [7:0] page;
    logic       last;
  } char_cell_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] number;
  logic [3:0]  digit_count;
  logic [7:0]  start_column;
  logic [7:0]  start_page;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  char_code;
  logic [7:0]  column;
  logic [7:0]  page;
  logic        last;

  char_cell_t  pending_chars[$];
  logic [7:0]  glyph_size;
  int          error_count;
  int          rx_hold_cycles;
  bit          idle_on;

  decimal_field_formatter_unit #(
    .MAX_DIGITS(MAX_DIGITS),
    .COLUMN_COUNT(COLUMN_COUNT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .number(number),
    .digit_count(digit_count),
    .start_column(start_column),
    .start_page(start_page),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .char_code(char_code),
    .column(column),
    .page(page),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expected characters of one request, most significant digit first
  function automatic void predict_field(input logic [31:0] num, input logic [3:0] cnt,
                                        input logic [7:0] col0, input logic [7:0] pg0);
    int unsigned      width;
    int unsigned      pitch;
    int unsigned      digit;
    longint unsigned  scale;
    bit               shown;
    bit               is_last;
    logic [7:0]       col_sum;
    char_cell_t       chr;
    width = (cnt > MAX_DIGITS) ? MAX_DIGITS : cnt;
    pitch = glyph_size >> 1;
    shown = 1'b0;
    for (int t = 0; t < width; t++) begin
      scale = 1;
      for (int p = 0; p < width - t - 1; p++) scale = scale * 10;
      digit = (longint'(num) / scale) % 10;
      is_last = (t + 1 == width);
      if (!shown && !is_last && digit == 0) begin
        chr.code = CODE_SPACE;
      end else begin
        shown = 1'b1;
        chr.code = CODE_ZERO + 6'(digit);
      end
      col_sum = 8'(int'(col0) + pitch * t);
      if (col_sum > COLUMN_COUNT - 1) begin
        chr.column = 8'd0;
        chr.page = pg0 + PAGE_STEP;
      end else begin
        chr.column = col_sum;
        chr.page = pg0;
      end
      chr.last = is_last;
      pending_chars.push_back(chr);
    end
  endfunction

  task automatic config_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == GLYPH_REG_ADDR) glyph_size = data[7:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_request(input logic [31:0] num, input logic [3:0] cnt,
                              input logic [7:0] col0, input logic [7:0] pg0);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    number = num;
    digit_count = cnt;
    start_column = col0;
    start_page = pg0;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_field(num, cnt, col0, pg0);
  endtask

  // drop valid, wait out every expected character and any zero-width request in flight
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_number();
    longint unsigned v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 9);
      2: v = $urandom_range(0, 99999);
      3: begin
        v = $urandom_range(1, 9);
        repeat ($urandom_range(0, 9)) v = v * 10;
      end
      default: begin
        v = 1;
        repeat ($urandom_range(1, 9)) v = v * 10;
        v = v + $urandom_range(0, 9);
      end
    endcase
    return v[31:0];
  endfunction

  task automatic send_random_request();
    logic [3:0] cnt;
    logic [7:0] col0;
    cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 10));
    col0 = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
    send_request(random_number(), cnt, col0, 8'($urandom_range(0, 255)));
  endtask

  // leading blanks, clamping, modulo, wrap of column and page at the default pitch
  task automatic test_directed_fields();
    send_request(32'd0, 4'd10, 8'd0, 8'd0);
    send_request(32'hFFFF_FFFF, 4'd10, 8'd0, 8'd0);
    send_request(32'hFFFF_FFFF, 4'd15, 8'd0, 8'd3);
    send_request(32'd1234567890, 4'd11, 8'd8, 8'd1);
    send_request(32'd77, 4'd0, 8'd0, 8'd0);
    send_request(32'd0, 4'd1, 8'd40, 8'd7);
    send_request(32'd1000000000, 4'd10, 8'd0, 8'd0);
    send_request(32'd1234567890, 4'd5, 8'd10, 8'd2);
    send_request(32'd5, 4'd4, 8'd64, 8'd4);
    send_request(32'd1005, 4'd4, 8'd0, 8'd0);
    send_request(32'd100, 4'd3, 8'd0, 8'd0);
    send_request(32'd987654321, 4'd9, 8'd255, 8'd255);
    send_request(32'd42, 4'd6, 8'd127, 8'd254);
    send_request(32'd9, 4'd2, 8'd120, 8'd255);
    send_request(32'd31415, 4'd8, 8'd128, 8'd0);
    send_request(32'hAAAA_AAAA, 4'd10, 8'hAA, 8'h55);
    send_request(32'h5555_5555, 4'd7, 8'h55, 8'hAA);
    wait_drain();
  endtask

  // pitch of zero, odd glyph heights and the largest glyph
  task automatic test_glyph_pitch();
    logic [7:0] sizes[4];
    sizes = '{8'd0, 8'd1, 8'd255, 8'd17};
    foreach (sizes[i]) begin
      config_write(GLYPH_REG_ADDR, {24'($urandom), sizes[i]});
      send_request(32'd123456789, 4'd10, 8'd5, 8'd9);
      send_request(32'hFFFF_FFFF, 4'd10, 8'd100, 8'd255);
      send_request(32'd7, 4'd3, 8'd127, 8'd0);
      wait_drain();
    end
  endtask

  // a write outside the register map leaves the pitch alone
  task automatic test_register_decode();
    config_write(GLYPH_REG_ADDR, 32'd16);
    config_write(UNUSED_REG_ADDR, 32'hFFFF_FF02);
    send_request(32'd24680, 4'd6, 8'd60, 8'd1);
    wait_drain();
  endtask

  // receiver holds off long enough for the block to fill and stall requests
  task automatic test_output_holdoff();
    rx_hold_cycles = 300;
    repeat (6) send_random_request();
    wait_drain();
  endtask

  // sender waits for all characters before each new burst
  task automatic test_sender_pause();
    repeat (3) begin
      repeat (4) send_random_request();
      wait_drain();
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] sizes[5];
    sizes = '{8'd16, 8'd255, 8'd0, 8'd9, 8'd24};
    foreach (sizes[i]) begin
      config_write(GLYPH_REG_ADDR, {24'($urandom), sizes[i]});
      if (i == 4) idle_on = 1'b0;
      repeat (56) send_random_request();
      wait_drain();
    end
  endtask

  // receiver side: long hold-off when asked, else random stall and ready bursts while idle_on is set
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall = 1'b1;
        rx_hold_cycles--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    char_cell_t exp_cell;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character code %0d column %0d page %0d last %0d",
                 $time, char_code, column, page, last);
        error_count++;
      end else begin
        exp_cell = pending_chars.pop_front();
        if (char_code !== exp_cell.code) begin
          $display("%0t: char_code expected %0d actual %0d", $time, exp_cell.code, char_code);
          error_count++;
        end
        if (column !== exp_cell.column) begin
          $display("%0t: column expected %0d actual %0d", $time, exp_cell.column, column);
          error_count++;
        end
        if (page !== exp_cell.page) begin
          $display("%0t: page expected %0d actual %0d", $time, exp_cell.page, page);
          error_count++;
        end
        if (last !== exp_cell.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_cell.last, last);
          error_count++;
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("decimal_field_formatter_unit_tb NOT OK");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    number = '0;
    digit_count = '0;
    start_column = '0;
    start_page = '0;
    glyph_size = GLYPH_RESET;
    error_count = 0;
    rx_hold_cycles = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_fields();
    test_glyph_pitch();
    test_register_decode();
    test_output_holdoff();
    test_sender_pause();
    test_random_traffic();

    wait_drain();
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("decimal_field_formatter_unit_tb OK");
    end else begin
      $display("decimal_field_formatter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
